[hw/rtl/pe_relocation_block_parser_assert.svh]
// Assertion macros for the relocation block parser checker.
// Depends on nothing; included by the checker file.
`ifndef PE_RELOCATION_BLOCK_PARSER_ASSERT_SVH
`define PE_RELOCATION_BLOCK_PARSER_ASSERT_SVH

// Check a same-cycle implication on every clock edge outside reset
`define PRP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("prp check failed: same-cycle implication");

// Check an implication whose consequence holds in the next cycle
`define PRP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("prp check failed: next-cycle implication");

`endif

[hw/rtl/prp_pkg.sv]
// Shared types and constants for the relocation block parser.
// No dependencies; imported by every module of the block.
package prp_pkg;

    // Default depth of the section table
    localparam int MAX_SECTIONS_DEF = 16;

    // Field widths
    localparam int SECT_INDEX_W = 4;
    localparam int ADDR_W       = 32;
    localparam int WORD_W       = 16;
    localparam int OFFSET_W     = 12;
    localparam int KIND_W       = 4;
    localparam int COUNT_W      = 5;
    localparam int LEFT_W       = 31;

    // Input tdata layout, lowest bit first
    localparam int IN_INDEX_LSB  = 0;
    localparam int IN_START_LSB  = IN_INDEX_LSB + SECT_INDEX_W;
    localparam int IN_LENGTH_LSB = IN_START_LSB + ADDR_W;
    localparam int IN_FILE_LSB   = IN_LENGTH_LSB + ADDR_W;
    localparam int IN_WORD_LSB   = IN_FILE_LSB + ADDR_W;
    localparam int IN_DATA_W     = ((IN_WORD_LSB + WORD_W + 7) / 8) * 8;

    // Output tdata / tuser layout
    localparam int OUT_DATA_W = 2 * ADDR_W;
    localparam int OUT_USER_W = 1 + KIND_W;

    // Block header size in bytes
    localparam logic [ADDR_W-1:0] HDR_BYTES = 32'd8;

    // Input command codes
    localparam logic CMD_SECTION_WRITE = 1'b0;
    localparam logic CMD_RELOC_WORD    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } prp_state_t;

    typedef enum logic [1:0] {
        PH_PAGE_LO,
        PH_PAGE_HI,
        PH_SIZE_LO,
        PH_SIZE_HI
    } hdr_phase_t;

    // What an accepted item turns into
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ENTRY,
        KIND_END
    } item_kind_t;

    typedef struct packed {
        logic take;
        logic search;
        logic load_out;
    } prp_cmd_t;

    typedef struct packed {
        item_kind_t kind;
        logic       search_done;
    } prp_status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] file_pos;
    } sect_entry_t;

endpackage

[hw/rtl/prp_ctrl.sv]
// Controller for the relocation block parser: item intake, search sequencing, output valid.
// Depends on prp_pkg.
module prp_ctrl
    import prp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  prp_status_t status,
    output prp_cmd_t    cmd
);

    prp_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.take = 1'b1;
                    case (status.kind)
                        KIND_ENTRY: state_next = ST_SEARCH;
                        KIND_END:   state_next = ST_EMIT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
                if (status.search_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Load the output register once it is free or draining
                if (!out_valid_reg || m_axis_tready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

endmodule

[hw/rtl/prp_datapath.sv]
// Datapath for the relocation block parser: section table memory, header parsing,
// address translation walk and result registers. Depends on prp_pkg.
module prp_datapath
    import prp_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [COUNT_W-1:0]    cfg_wr_data,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  prp_cmd_t              cmd,
    output prp_status_t           status,
    output logic [ADDR_W-1:0]     out_rva,
    output logic [ADDR_W-1:0]     out_file_pos,
    output logic                  out_found,
    output logic [KIND_W-1:0]     out_kind,
    output logic                  out_end
);

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

    // Input field decode
    logic [SECT_INDEX_W-1:0] in_index;
    logic [ADDR_W-1:0]       in_start;
    logic [ADDR_W-1:0]       in_length;
    logic [ADDR_W-1:0]       in_file_pos;
    logic [WORD_W-1:0]       in_word;
    logic                    in_command;

    assign in_index    = s_axis_tdata[IN_INDEX_LSB +: SECT_INDEX_W];
    assign in_start    = s_axis_tdata[IN_START_LSB +: ADDR_W];
    assign in_length   = s_axis_tdata[IN_LENGTH_LSB +: ADDR_W];
    assign in_file_pos = s_axis_tdata[IN_FILE_LSB +: ADDR_W];
    assign in_word     = s_axis_tdata[IN_WORD_LSB +: WORD_W];
    assign in_command  = s_axis_tuser;

    // Parse state
    logic [COUNT_W-1:0] section_count_reg;
    logic [ADDR_W-1:0]  page_reg;
    logic [ADDR_W-1:0]  size_reg;
    logic [LEFT_W-1:0]  entries_left_reg;
    hdr_phase_t         phase_reg;
    logic               done_reg;

    // Section table and walk
    sect_entry_t        sect_mem [MAX_SECTIONS];
    sect_entry_t        mem_q_reg;
    logic [ADDR_W-1:0]  sect0_start_reg;
    logic [IDX_W-1:0]   walk_idx_reg, walk_idx_next;

    // Entry being translated and result staging
    logic [ADDR_W-1:0]  rva_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [ADDR_W-1:0]  stage_rva_reg, stage_pos_reg;
    logic               stage_found_reg, stage_end_reg;
    logic [KIND_W-1:0]  stage_kind_reg;
    logic [ADDR_W-1:0]  out_rva_reg, out_pos_reg;
    logic               out_found_reg, out_end_reg;
    logic [KIND_W-1:0]  out_kind_reg;

    logic [ADDR_W-1:0]  size_full;
    logic               dir_word;
    logic               sect_write;
    item_kind_t         item_kind;

    assign size_full  = {in_word, size_reg[WORD_W-1:0]};
    assign dir_word   = cmd.take && (in_command == CMD_RELOC_WORD) && !done_reg;
    assign sect_write = cmd.take && (in_command == CMD_SECTION_WRITE)
                        && (int'(in_index) < MAX_SECTIONS);

    // Classify the offered item
    always_comb begin
        item_kind = KIND_NONE;
        if ((in_command == CMD_RELOC_WORD) && !done_reg) begin
            if (entries_left_reg != '0) begin
                item_kind = KIND_ENTRY;
            end else if ((phase_reg == PH_SIZE_HI) && (size_full == '0)) begin
                item_kind = KIND_END;
            end
        end
    end

    // Clamp the configured count to the table depth
    logic [CNT_W-1:0] sect_limit;
    always_comb begin
        if (int'(section_count_reg) > MAX_SECTIONS) begin
            sect_limit = CNT_W'(MAX_SECTIONS);
        end else begin
            sect_limit = CNT_W'(section_count_reg);
        end
    end

    // Compare the current table entry against the entry address
    logic [CNT_W-1:0]  walk_pos;
    logic [ADDR_W:0]   range_hi;
    logic              idx_ok, in_range, below_first, hit, last, search_done;
    logic [ADDR_W-1:0] hit_pos;

    assign walk_pos    = CNT_W'(walk_idx_reg);
    assign idx_ok      = walk_pos < sect_limit;
    assign range_hi    = {1'b0, mem_q_reg.start} + {1'b0, mem_q_reg.length};
    assign in_range    = (rva_reg >= mem_q_reg.start) && ({1'b0, rva_reg} < range_hi);
    assign below_first = rva_reg < sect0_start_reg;
    assign hit         = idx_ok && in_range;
    assign last        = !idx_ok || ((walk_pos + CNT_W'(1)) >= sect_limit);
    assign search_done = below_first || hit || last;
    assign hit_pos     = rva_reg - mem_q_reg.start + mem_q_reg.file_pos;

    // Walk index: restart on intake, advance while searching
    always_comb begin
        walk_idx_next = walk_idx_reg;
        if (cmd.take) begin
            walk_idx_next = '0;
        end else if (cmd.search && !search_done) begin
            walk_idx_next = walk_idx_reg + IDX_W'(1);
        end
    end

    // Control and parse registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            section_count_reg <= '0;
            page_reg          <= '0;
            size_reg          <= '0;
            entries_left_reg  <= '0;
            phase_reg         <= PH_PAGE_LO;
            done_reg          <= 1'b0;
            walk_idx_reg      <= '0;
        end else begin
            walk_idx_reg <= walk_idx_next;
            if (cfg_wr_en) begin
                section_count_reg <= cfg_wr_data;
            end
            if (dir_word) begin
                if (entries_left_reg != '0) begin
                    entries_left_reg <= entries_left_reg - LEFT_W'(1);
                end else begin
                    case (phase_reg)
                        PH_PAGE_LO: begin
                            page_reg  <= {{(ADDR_W-WORD_W){1'b0}}, in_word};
                            phase_reg <= PH_PAGE_HI;
                        end
                        PH_PAGE_HI: begin
                            page_reg  <= {in_word, page_reg[WORD_W-1:0]};
                            phase_reg <= PH_SIZE_LO;
                        end
                        PH_SIZE_LO: begin
                            size_reg  <= {{(ADDR_W-WORD_W){1'b0}}, in_word};
                            phase_reg <= PH_SIZE_HI;
                        end
                        PH_SIZE_HI: begin
                            size_reg  <= size_full;
                            phase_reg <= PH_PAGE_LO;
                            if (size_full == '0) begin
                                done_reg <= 1'b1;
                            end else if (size_full >= HDR_BYTES) begin
                                entries_left_reg <= LEFT_W'((size_full - HDR_BYTES) >> 1);
                            end else begin
                                entries_left_reg <= '0;
                            end
                        end
                        default: phase_reg <= PH_PAGE_LO;
                    endcase
                end
            end
        end
    end

    // Section table memory with registered read
    always_ff @(posedge aclk) begin
        if (sect_write) begin
            sect_mem[IDX_W'(in_index)] <= '{start: in_start, length: in_length,
                                            file_pos: in_file_pos};
        end
        mem_q_reg <= sect_mem[walk_idx_next];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (sect_write && (in_index == '0)) begin
            sect0_start_reg <= in_start;
        end
        if (cmd.take && (item_kind == KIND_ENTRY)) begin
            rva_reg  <= page_reg + {{(ADDR_W-OFFSET_W){1'b0}}, in_word[OFFSET_W-1:0]};
            kind_reg <= in_word[WORD_W-1 -: KIND_W];
        end
        // Stage the end marker or the finished translation
        if (cmd.take && (item_kind == KIND_END)) begin
            stage_rva_reg   <= '0;
            stage_pos_reg   <= '0;
            stage_found_reg <= 1'b0;
            stage_kind_reg  <= '0;
            stage_end_reg   <= 1'b1;
        end else if (cmd.search && search_done) begin
            stage_rva_reg   <= rva_reg;
            stage_pos_reg   <= below_first ? rva_reg : (hit ? hit_pos : '0);
            stage_found_reg <= below_first || hit;
            stage_kind_reg  <= kind_reg;
            stage_end_reg   <= 1'b0;
        end
        if (cmd.load_out) begin
            out_rva_reg   <= stage_rva_reg;
            out_pos_reg   <= stage_pos_reg;
            out_found_reg <= stage_found_reg;
            out_kind_reg  <= stage_kind_reg;
            out_end_reg   <= stage_end_reg;
        end
    end

    assign status.kind        = item_kind;
    assign status.search_done = search_done;

    assign out_rva      = out_rva_reg;
    assign out_file_pos = out_pos_reg;
    assign out_found    = out_found_reg;
    assign out_kind     = out_kind_reg;
    assign out_end      = out_end_reg;

endmodule

[hw/rtl/pe_relocation_block_parser.sv]
// Section writes, header words and ignored words are taken in the idle state and keep it;
// the zero-size header that ends the table emits an end marker instead. An entry word
// walks the table, reading one section table entry per cycle from a single memory read
// port, then loads its result into the output register; the next item is taken after that
// load, which waits while a stalled result holds the output register.
// Reset clears the parse state, section_count and output valid; the table is not cleared.
module pe_relocation_block_parser
    import prp_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration: section_count
    input  logic                   cfg_wr_en,
    input  logic [COUNT_W-1:0]     cfg_wr_data,
    // Input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // section_index[3:0], section_start[35:4], section_length[67:36],
    // section_file_pos[99:68], reloc_word[115:100], zero fill[119:116]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // command[0]
    input  logic [0:0]             s_axis_tuser,
    // Result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // entry_rva[31:0], entry_file_pos[63:32]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // found[0], reloc_kind[4:1]
    output logic [OUT_USER_W-1:0]  m_axis_tuser,
    // end_of_table
    output logic                   m_axis_tlast
);

    prp_cmd_t          cmd;
    prp_status_t       status;
    logic [ADDR_W-1:0] out_rva, out_file_pos;
    logic              out_found, out_end;
    logic [KIND_W-1:0] out_kind;

    prp_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    prp_datapath #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser[0]),
        .cmd          (cmd),
        .status       (status),
        .out_rva      (out_rva),
        .out_file_pos (out_file_pos),
        .out_found    (out_found),
        .out_kind     (out_kind),
        .out_end      (out_end)
    );

    // Pack result fields onto the stream
    assign m_axis_tdata = {out_file_pos, out_rva};
    assign m_axis_tuser = {out_kind, out_found};
    assign m_axis_tlast = out_end;

endmodule

[hw/rtl/prp_checker.sv]
// Port-level checks for the relocation block parser, bound to the top level.
// Depends on prp_pkg and pe_relocation_block_parser_assert.svh.
`include "pe_relocation_block_parser_assert.svh"

module prp_checker
    import prp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_wr_en,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [0:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser,
    input logic                  m_axis_tlast
);

    // Hold a stalled result steady
    `PRP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Hold a waiting input item steady
    `PRP_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))

    // Write the configuration only while the block is idle
    `PRP_ASSERT_IMPL(a_cfg_quiet, aclk, aresetn, cfg_wr_en, s_axis_tready && !m_axis_tvalid)

    // End marker carries all other fields zero
    `PRP_ASSERT_IMPL(a_end_clean, aclk, aresetn, m_axis_tvalid && m_axis_tlast, (m_axis_tdata == '0) && (m_axis_tuser == '0))

    // A miss reports file position zero
    `PRP_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[OUT_DATA_W-1:ADDR_W] == '0)

endmodule

bind pe_relocation_block_parser prp_checker u_prp_checker (.*);
